### rtl/core/utf8_two_byte_decoder_defines.svh
// Assertion macros shared by the UTF-8 two-byte decoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef UTF8_TWO_BYTE_DECODER_DEFINES_SVH
`define UTF8_TWO_BYTE_DECODER_DEFINES_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define UTF8D_ASSERT_SAME(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |-> (conseq)) else $error("utf8d check failed");

// Condition in this cycle implies a consequence in the next cycle.
`define UTF8D_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |=> (conseq)) else $error("utf8d check failed");

`endif

### rtl/core/utf8d_pkg.sv
// Types and constants of the UTF-8 two-byte decoder.
// Used by the channel interfaces and by every decoder module.
package utf8d_pkg;

    // Decoder mode between bytes.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_LEAD = 2'd1,
        MODE_SKIP = 2'd2
    } t_mode;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CODE_W  = 12;
    localparam int unsigned LEAD_W  = 5;
    localparam int unsigned CONT_W  = 6;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_TAG  = 8'hC0;

    localparam logic signed [CODE_W-1:0] UNKNOWN_CODE = -12'sd1;

    // One result item.
    typedef struct packed {
        logic signed [CODE_W-1:0] glyph_code;
        logic                     run_last;
        logic                     text_end_out;
    } t_result;

    // Results that one byte hands to the result buffer.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

### rtl/core/utf8d_channels.sv
// Valid/ready channel interfaces of the UTF-8 two-byte decoder.
// Depends on utf8d_pkg for field widths.

// Byte channel into the decoder.
interface utf8d_byte_if;
    logic                           valid;
    logic                           ready;
    logic [utf8d_pkg::BYTE_W-1:0]   text_byte;
    logic                           text_end_in;

    modport source (output valid, output text_byte, output text_end_in, input ready);
    modport sink   (input valid, input text_byte, input text_end_in, output ready);
endinterface

// Code point channel out of the decoder.
interface utf8d_code_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [utf8d_pkg::CODE_W-1:0]  glyph_code;
    logic                                 run_last;
    logic                                 text_end_out;

    modport source (output valid, output glyph_code, output run_last,
                    output text_end_out, input ready);
    modport sink   (input valid, input glyph_code, input run_last,
                    input text_end_out, output ready);
endinterface

### rtl/core/utf8d_decode.sv
// Input register, mode state and per-byte decode of the UTF-8 decoder.
// Depends on utf8d_pkg, utf8d_byte_if and the assertion macro header.
`include "utf8_two_byte_decoder_defines.svh"

module utf8d_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    utf8d_byte_if.sink       i_text,
    input  logic             i_space,
    output utf8d_pkg::t_push o_push
);
    import utf8d_pkg::*;

    logic                r_valid;
    logic [BYTE_W-1:0]   r_byte;
    logic                r_end;
    t_mode               r_mode;
    t_mode               n_mode;
    logic [LEAD_W-1:0]   r_lead;
    logic [LEAD_W-1:0]   n_lead;

    logic                is_cont;
    logic                is_ascii;
    logic                is_lead;
    logic                pre_unk;
    logic                fresh;
    logic                main_hit;
    logic [CODE_W-1:0]   main_code;
    logic                end_unk;
    logic [1:0]          cnt;
    t_result             res0;
    t_result             res1;
    logic                consume;

    // Byte classes.
    assign is_cont  = (r_byte & CONT_MASK) == CONT_TAG;
    assign is_lead  = (r_byte & LEAD_MASK) == LEAD_TAG;
    assign is_ascii = !r_byte[BYTE_W-1];

    // Decode of the held byte against the current mode.
    always_comb begin
        n_mode    = r_mode;
        n_lead    = r_lead;
        pre_unk   = 1'b0;
        fresh     = 1'b0;
        main_hit  = 1'b0;
        main_code = '0;
        end_unk   = 1'b0;
        cnt       = 2'd0;
        res0      = '0;
        res1      = '0;

        case (r_mode)
            MODE_LEAD: begin
                if (is_cont) begin
                    main_hit  = 1'b1;
                    main_code = {1'b0, r_lead, r_byte[CONT_W-1:0]};
                    n_mode    = MODE_IDLE;
                end else begin
                    pre_unk = 1'b1;
                    fresh   = 1'b1;
                end
            end
            MODE_SKIP: begin
                if (!is_cont) begin
                    pre_unk = 1'b1;
                    fresh   = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        // The byte opens a new sequence.
        if (fresh) begin
            if (is_ascii) begin
                main_hit  = 1'b1;
                main_code = {{(CODE_W-BYTE_W){1'b0}}, r_byte};
                n_mode    = MODE_IDLE;
            end else if (is_lead) begin
                n_mode = MODE_LEAD;
                n_lead = r_byte[LEAD_W-1:0];
            end else begin
                n_mode = MODE_SKIP;
            end
        end

        // End of text closes any pending sequence.
        if (r_end) begin
            end_unk = (n_mode != MODE_IDLE);
            n_mode  = MODE_IDLE;
            n_lead  = '0;
        end

        // Pack the results in order.
        if (pre_unk) begin
            res0.glyph_code = UNKNOWN_CODE;
            cnt             = 2'd1;
        end
        if (main_hit) begin
            if (cnt == 2'd0) begin
                res0.glyph_code = main_code;
            end else begin
                res1.glyph_code = main_code;
            end
            cnt = cnt + 2'd1;
        end
        if (end_unk) begin
            if (cnt == 2'd0) begin
                res0.glyph_code = UNKNOWN_CODE;
            end else begin
                res1.glyph_code = UNKNOWN_CODE;
            end
            cnt = cnt + 2'd1;
        end

        // Flags go on the last result of the byte.
        if (cnt == 2'd1) begin
            res0.run_last     = 1'b1;
            res0.text_end_out = r_end;
        end else if (cnt == 2'd2) begin
            res1.run_last     = 1'b1;
            res1.text_end_out = r_end;
        end
    end

    // A byte leaves the input register when its results fit in the buffer.
    assign consume      = r_valid && ((cnt == 2'd0) || i_space);
    assign i_text.ready = !r_valid || consume;

    assign o_push.count = consume ? cnt : 2'd0;
    assign o_push.res0  = res0;
    assign o_push.res1  = res1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_byte <= i_text.text_byte;
            r_end  <= i_text.text_end_in;
        end
    end

    // Mode and pending lead bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_lead <= '0;
        end else if (consume) begin
            r_mode <= n_mode;
            r_lead <= n_lead;
        end
    end

    `UTF8D_ASSERT_NEXT(a_end_clears_state, i_clk, i_rst_n, consume && r_end,
        (r_mode == MODE_IDLE) && (r_lead == '0))
    `UTF8D_ASSERT_SAME(a_end_gives_result, i_clk, i_rst_n, consume && r_end,
        o_push.count != 2'd0)

endmodule

### rtl/core/utf8d_rbuf.sv
// Result buffer of the UTF-8 decoder: a small queue of result items.
// Depends on utf8d_pkg, utf8d_code_if and the assertion macro header.
`include "utf8_two_byte_decoder_defines.svh"

module utf8d_rbuf #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  utf8d_pkg::t_push i_push,
    output logic             o_space,
    utf8d_code_if.source     o_glyph
);
    import utf8d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] SPACE_MAX = CNT_W'(DEPTH - 2);

    t_result           r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  wr_next;
    logic [PTR_W-1:0]  wr_after;
    logic              pop;
    t_result           head;

    // Pointer wrap for any depth.
    assign wr_next  = (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
    assign wr_after = (wr_next == LAST_PTR) ? '0 : wr_next + PTR_W'(1);

    // Room for a full pair of results.
    assign o_space = r_count <= SPACE_MAX;

    assign head                 = r_mem[r_rd];
    assign pop                  = o_glyph.valid && o_glyph.ready;
    assign o_glyph.valid        = r_count != '0;
    assign o_glyph.glyph_code   = head.glyph_code;
    assign o_glyph.run_last     = head.run_last;
    assign o_glyph.text_end_out = head.text_end_out;

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.count == 2'd1) begin
                r_wr <= wr_next;
            end else if (i_push.count == 2'd2) begin
                r_wr <= wr_after;
            end
            if (pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push.count) - CNT_W'(pop);
        end
    end

    `UTF8D_ASSERT_SAME(a_push_has_room, i_clk, i_rst_n, i_push.count != 2'd0,
        r_count <= SPACE_MAX)
    `UTF8D_ASSERT_SAME(a_empty_aligned, i_clk, i_rst_n, r_count == '0, r_wr == r_rd)

endmodule

### rtl/core/utf8_two_byte_decoder.sv
// Top level of the UTF-8 two-byte decoder.
// Depends on utf8d_pkg, the channel interfaces, utf8d_decode and utf8d_rbuf.

// Decodes a byte stream into code points: ASCII passes through, a 110xxxxx
// lead with a 10xxxxxx continuation gives an 11-bit code point, and anything
// else gives -1 once per broken sequence. One byte is taken per clock while
// the result queue has room for two results or the byte yields none; a byte
// can yield two results (an unknown, then its own code or the end-of-text
// unknown). The output port gives one result per cycle while the receiver is
// ready. A byte passes through the input register and the result queue before
// its first result appears. Input ready does not depend on output ready; the
// queue depth RBUF_DEPTH (at least 2) sets how much output stall is absorbed.
module utf8_two_byte_decoder #(
    parameter int unsigned RBUF_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    utf8d_byte_if.sink   i_text,
    utf8d_code_if.source o_glyph
);
    import utf8d_pkg::*;

    t_push push;
    logic  space;

    // Byte decode and mode state.
    utf8d_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (i_text),
        .i_space (space),
        .o_push  (push)
    );

    // Result queue toward the output channel.
    utf8d_rbuf #(
        .DEPTH (RBUF_DEPTH)
    ) u_rbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_glyph (o_glyph)
    );

endmodule

### verif/glyph_checker.sv
// Checker for the UTF-8 two-byte decoder: predicts code points from accepted bytes.
// Compares every accepted result item against the oldest prediction.
// Depends on utf8d_pkg for the mode enum, result struct and byte constants.
module glyph_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_byte_valid,
    input  logic                               i_byte_ready,
    input  logic [utf8d_pkg::BYTE_W-1:0]       i_text_byte,
    input  logic                               i_text_end_in,
    input  logic                               i_glyph_valid,
    input  logic                               i_glyph_ready,
    input  logic signed [utf8d_pkg::CODE_W-1:0] i_glyph_code,
    input  logic                               i_run_last,
    input  logic                               i_text_end_out,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import utf8d_pkg::*;

    t_mode             mode_q;
    logic [LEAD_W-1:0] lead_q;
    t_result           expected_glyphs[$];
    int                fail_count = 0;
    int                pending_glyphs = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_glyphs;

    // Only the first ten failures are printed; the rest are counted.
    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("glyph_checker: %s", what);
        end
    endtask

    function automatic t_result make_glyph(input logic signed [CODE_W-1:0] code);
        t_result r;
        r.glyph_code   = code;
        r.run_last     = 1'b0;
        r.text_end_out = 1'b0;
        return r;
    endfunction

    // Advance the decode state by one byte and queue the code points it yields.
    task automatic predict_glyphs(input logic [BYTE_W-1:0] b, input logic last_byte);
        t_result step_glyphs[$];
        t_result r;
        logic    is_cont;
        logic    restart;
        int      last_idx;
        is_cont = (b & CONT_MASK) == CONT_TAG;
        restart = 1'b0;
        case (mode_q)
            MODE_LEAD: begin
                if (is_cont) begin
                    step_glyphs.push_back(make_glyph({1'b0, lead_q, b[CONT_W-1:0]}));
                    mode_q = MODE_IDLE;
                end else begin
                    step_glyphs.push_back(make_glyph(UNKNOWN_CODE));
                    restart = 1'b1;
                end
            end
            MODE_SKIP: begin
                // Continuation bytes are swallowed while an unknown is pending.
                if (!is_cont) begin
                    step_glyphs.push_back(make_glyph(UNKNOWN_CODE));
                    restart = 1'b1;
                end
            end
            default: begin
                restart = 1'b1;
            end
        endcase

        // The byte opens a new sequence as if the decoder were idle.
        if (restart) begin
            if (b < CONT_TAG) begin
                step_glyphs.push_back(make_glyph({{(CODE_W-BYTE_W){1'b0}}, b}));
                mode_q = MODE_IDLE;
            end else if ((b & LEAD_MASK) == LEAD_TAG) begin
                mode_q = MODE_LEAD;
                lead_q = b[LEAD_W-1:0];
            end else begin
                mode_q = MODE_SKIP;
            end
        end

        // End of text closes whatever is still pending.
        if (last_byte) begin
            if (mode_q != MODE_IDLE) begin
                step_glyphs.push_back(make_glyph(UNKNOWN_CODE));
            end
            mode_q = MODE_IDLE;
            lead_q = '0;
            last_idx = step_glyphs.size() - 1;
            r = step_glyphs[last_idx];
            r.text_end_out = 1'b1;
            step_glyphs[last_idx] = r;
        end

        // The last result of the byte carries the run flag.
        if (step_glyphs.size() > 0) begin
            last_idx = step_glyphs.size() - 1;
            r = step_glyphs[last_idx];
            r.run_last = 1'b1;
            step_glyphs[last_idx] = r;
        end
        foreach (step_glyphs[k]) begin
            expected_glyphs.push_back(step_glyphs[k]);
        end
    endtask

    // Compare results first; a byte accepted at this edge cannot have caused one yet.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            mode_q = MODE_IDLE;
            lead_q = '0;
            expected_glyphs.delete();
        end else begin
            if (i_glyph_valid && i_glyph_ready) begin
                if (expected_glyphs.size() == 0) begin
                    report_failure($sformatf("unexpected item: code %0d last %0b end %0b",
                                             i_glyph_code, i_run_last, i_text_end_out));
                end else begin
                    want = expected_glyphs.pop_front();
                    if (want.glyph_code !== i_glyph_code || want.run_last !== i_run_last ||
                        want.text_end_out !== i_text_end_out) begin
                        report_failure($sformatf(
                            "expected code %0d last %0b end %0b, got code %0d last %0b end %0b",
                            want.glyph_code, want.run_last, want.text_end_out,
                            i_glyph_code, i_run_last, i_text_end_out));
                    end
                end
            end
            if (i_byte_valid && i_byte_ready) begin
                predict_glyphs(i_text_byte, i_text_end_in);
            end
        end
        pending_glyphs = expected_glyphs.size();
    end

endmodule

### verif/tb_top.sv
// Testbench top for the UTF-8 two-byte decoder: clock, reset, byte stimulus and verdict.
// Depends on utf8d_pkg, the channel interfaces, the decoder RTL and glyph_checker.
module tb_top;
    import utf8d_pkg::*;

    localparam int N_ITEMS        = 550;
    localparam int IDLE_END       = 440;
    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_DIRECTED     = 27;

    // Directed bytes, with the end-of-text flag in the top bit.
    localparam logic [BYTE_W:0] DIRECTED_BYTES [N_DIRECTED] = '{
        9'h000, 9'h07F,                 // ASCII extremes
        9'h0C0, 9'h080,                 // overlong zero
        9'h0DF, 9'h0BF,                 // largest code point
        9'h0C3, 9'h041,                 // lead broken by ASCII
        9'h0C5, 9'h0C6, 9'h081,         // lead broken by another lead
        9'h080, 9'h0BF, 9'h07E,         // stray continuation swallows the next one
        9'h0E0, 9'h080, 9'h0FF,         // long start, then another bad start
        9'h041,                         // ASCII closes the pending unknown
        9'h1D0,                         // lone lead at end of text
        9'h1F0,                         // bad start at end of text
        9'h0E2, 9'h180,                 // swallowed continuation at end of text
        9'h15A,                         // ASCII at end of text
        9'h0C2, 9'h1A9,                 // complete pair at end of text
        9'h0C4, 9'h155                  // broken lead with ASCII at end of text
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    utf8d_byte_if text_if ();
    utf8d_code_if glyph_if ();

    int fail_count;
    int pending_glyphs;
    int sent_count   = 0;
    int quiet_cycles = 0;
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit hold_req     = 1'b0;

    always #6 i_clk = ~i_clk;

    utf8_two_byte_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_if),
        .o_glyph (glyph_if)
    );

    glyph_checker u_glyph_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_valid   (text_if.valid),
        .i_byte_ready   (text_if.ready),
        .i_text_byte    (text_if.text_byte),
        .i_text_end_in  (text_if.text_end_in),
        .i_glyph_valid  (glyph_if.valid),
        .i_glyph_ready  (glyph_if.ready),
        .i_glyph_code   (glyph_if.glyph_code),
        .i_run_last     (glyph_if.run_last),
        .i_text_end_out (glyph_if.text_end_out),
        .o_fail_count   (fail_count),
        .o_pending      (pending_glyphs)
    );

    function automatic logic rand_end();
        return $urandom_range(0, 15) == 0;
    endfunction

    // Offer one item at the falling edge and hold it until it is accepted.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last_byte);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            text_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        text_if.valid       <= 1'b1;
        text_if.text_byte   <= b;
        text_if.text_end_in <= last_byte;
        do @(posedge i_clk); while (!text_if.ready);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Byte stimulus: directed cases, then mostly well-formed random sequences.
    initial begin : stimulus
        int   holds_done;
        int   kind;
        bit   in_pressure;
        logic [BYTE_W-1:0] b;
        holds_done          = 0;
        text_if.valid       = 1'b0;
        text_if.text_byte   = '0;
        text_if.text_end_in = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_BYTES[k]) begin
            send_byte(DIRECTED_BYTES[k][BYTE_W-1:0], DIRECTED_BYTES[k][BYTE_W]);
        end

        while (sent_count < N_ITEMS) begin
            // Two windows where the receiver holds off and the sender never pauses.
            in_pressure = (sent_count >= 150 && sent_count < 190) ||
                          (sent_count >= 320 && sent_count < 360);
            if ((holds_done == 0 && sent_count >= 150) ||
                (holds_done == 1 && sent_count >= 320)) begin
                hold_req = 1'b1;
                holds_done++;
            end
            src_idle_on  = (sent_count < IDLE_END) && !in_pressure;
            sink_idle_on = sent_count < IDLE_END;

            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    send_byte(8'($urandom_range(0, 127)), rand_end());
                end
                4, 5, 6: begin
                    send_byte(8'($urandom_range(0, 31)) | LEAD_TAG, rand_end());
                    send_byte(8'($urandom_range(0, 63)) | CONT_TAG, rand_end());
                end
                7: begin
                    // Lead followed by anything but a continuation.
                    send_byte(8'($urandom_range(0, 31)) | LEAD_TAG, rand_end());
                    b = 8'($urandom_range(0, 255));
                    if ((b & CONT_MASK) == CONT_TAG) begin
                        b = b ^ 8'h40;
                    end
                    send_byte(b, rand_end());
                end
                8: begin
                    // Start byte of a longer sequence, with its continuations.
                    send_byte(8'($urandom_range(0, 31)) | LEAD_MASK, rand_end());
                    repeat ($urandom_range(0, 3)) begin
                        send_byte(8'($urandom_range(0, 63)) | CONT_TAG, rand_end());
                    end
                end
                default: begin
                    send_byte(8'($urandom_range(0, 255)), rand_end());
                end
            endcase
        end
        text_if.valid <= 1'b0;

        // Drain the results, then allow for the decoder's latency.
        while (pending_glyphs != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Result receiver: random stall bursts and the long hold-offs on request.
    initial begin : result_sink
        glyph_if.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                glyph_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                glyph_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end else begin
                glyph_if.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Watchdog on cycles in which no item moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (text_if.valid && text_if.ready) ||
            (glyph_if.valid && glyph_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_channels.sv
rtl/core/utf8d_decode.sv
rtl/core/utf8d_rbuf.sv
rtl/core/utf8_two_byte_decoder.sv
verif/glyph_checker.sv
verif/tb_top.sv
